### design/sdi12_pkg.sv
// ----------------------------------------------------------------------------
// sdi12_pkg
// Shared types, request codes and constants for the SDI-12 line transceiver.
// ----------------------------------------------------------------------------
package sdi12_pkg;

   // Receive ring geometry
   localparam int RING_DEPTH = 64;
   localparam int RING_AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int FILL_W     = 6;

   localparam int CHAR_W  = 7;
   localparam int TICK_W  = 16;
   localparam int FRAME_W = 10;
   localparam int BIT_W   = 4;
   localparam int CSR_IW  = 2;

   // Host request codes
   typedef enum logic [3:0] {
      REQ_TICK    = 4'd0,
      REQ_WAKE    = 4'd1,
      REQ_SEND    = 4'd2,
      REQ_LISTEN  = 4'd3,
      REQ_HOLD    = 4'd4,
      REQ_DISABLE = 4'd5,
      REQ_READ    = 4'd6,
      REQ_PEEK    = 4'd7,
      REQ_FLUSH   = 4'd8
   } req_code_type;

   // Line modes as reported
   localparam logic [1:0] MODE_HOLD   = 2'd0;
   localparam logic [1:0] MODE_TX     = 2'd1;
   localparam logic [1:0] MODE_LISTEN = 2'd2;
   localparam logic [1:0] MODE_OFF    = 2'd3;

   // Configuration register indexes
   localparam logic [CSR_IW-1:0] CSR_BIT_TICKS  = 2'd0;
   localparam logic [CSR_IW-1:0] CSR_WAKE_HIGH  = 2'd1;
   localparam logic [CSR_IW-1:0] CSR_WAKE_LOW   = 2'd2;

   localparam logic [TICK_W-1:0] BIT_TICKS_RST = 16'd830;
   localparam logic [TICK_W-1:0] WAKE_HIGH_RST = 16'd12100;
   localparam logic [TICK_W-1:0] WAKE_LOW_RST  = 16'd8400;

   typedef struct packed {
      logic [TICK_W-1:0] bit_ticks;
      logic [TICK_W-1:0] wake_high;
      logic [TICK_W-1:0] wake_low;
   } line_cfg_type;

   typedef struct packed {
      logic              tick;
      logic              line;
      logic              listen;
      logic              wake;
      logic              send;
      logic              rx_abort;
      logic [CHAR_W-1:0] tx_char;
   } line_cmd_type;

   typedef struct packed {
      logic busy;
      logic level;
   } line_stat_type;

   typedef struct packed {
      logic              valid;
      logic [CHAR_W-1:0] data;
   } line_push_type;

   // Start bit high, data+even parity LSB first with 1 driven low, stop low
   function automatic logic [FRAME_W-1:0] build_frame(input logic [CHAR_W-1:0] c);
      logic [CHAR_W:0]    d;
      logic [FRAME_W-1:0] f;
      d = {^c, c};
      f = '0;
      f[0] = 1'b1;
      f[CHAR_W+1:1] = ~d;
      return f;
   endfunction

endpackage

### design/sdi12_ring_ram.sv
// ----------------------------------------------------------------------------
// sdi12_ring_ram
// Receive ring storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module sdi12_ring_ram
   import sdi12_pkg::*;
(
   input  logic               clock,
   input  logic               wr_en,
   input  logic [RING_AW-1:0] wr_addr,
   input  logic [CHAR_W-1:0]  wr_data,
   input  logic               rd_en,
   input  logic [RING_AW-1:0] rd_addr,
   output logic [CHAR_W-1:0]  rd_data
);

   logic [CHAR_W-1:0] mem [RING_DEPTH];
   logic [CHAR_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/sdi12_line_engine.sv
// ----------------------------------------------------------------------------
// sdi12_line_engine
// Bit timing for wake break, frame transmit and character receive.
// ----------------------------------------------------------------------------
module sdi12_line_engine
   import sdi12_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  line_cfg_type  cfg,
   input  line_cmd_type  cmd,
   output line_stat_type stat,
   output line_push_type push
);

   typedef enum logic [1:0] {
      TX_IDLE    = 2'd0,
      TX_WAKE_HI = 2'd1,
      TX_WAKE_LO = 2'd2,
      TX_FRAME   = 2'd3
   } tx_phase_type;

   localparam logic [BIT_W-1:0] TX_LAST_BIT = BIT_W'(FRAME_W - 1);
   localparam logic [BIT_W-1:0] RX_STOP_BIT = 4'd9;

   tx_phase_type       tx_phase_ff, tx_phase_in;
   logic [FRAME_W-1:0] tx_frame_ff, tx_frame_in;
   logic [BIT_W-1:0]   tx_idx_ff,   tx_idx_in;
   logic [TICK_W-1:0]  tx_timer_ff, tx_timer_in;
   logic               rx_active_ff, rx_active_in;
   logic [BIT_W-1:0]   rx_idx_ff,   rx_idx_in;
   logic [TICK_W-1:0]  rx_timer_ff, rx_timer_in;
   logic [CHAR_W-1:0]  rx_shift_ff, rx_shift_in;

   always_comb begin
      tx_phase_in  = tx_phase_ff;
      tx_frame_in  = tx_frame_ff;
      tx_idx_in    = tx_idx_ff;
      tx_timer_in  = tx_timer_ff;
      rx_active_in = rx_active_ff;
      rx_idx_in    = rx_idx_ff;
      rx_timer_in  = rx_timer_ff;
      rx_shift_in  = rx_shift_ff;
      push         = '0;
      push.data    = rx_shift_ff;

      if (cmd.tick) begin
         // transmit side
         if (tx_phase_ff != TX_IDLE) begin
            if (tx_timer_ff <= 16'd1) begin
               tx_timer_in = '0;
               unique case (tx_phase_ff)
                  TX_WAKE_HI: begin
                     tx_phase_in = TX_WAKE_LO;
                     tx_timer_in = cfg.wake_low;
                  end
                  TX_WAKE_LO: begin
                     tx_phase_in = TX_IDLE;
                  end
                  TX_FRAME: begin
                     if (tx_idx_ff >= TX_LAST_BIT) begin
                        tx_phase_in = TX_IDLE;
                        tx_idx_in   = '0;
                     end else begin
                        tx_idx_in   = tx_idx_ff + 4'd1;
                        tx_timer_in = cfg.bit_ticks;
                     end
                  end
                  default: begin
                     tx_phase_in = TX_IDLE;
                  end
               endcase
            end else begin
               tx_timer_in = tx_timer_ff - 16'd1;
            end
         end

         // receive side
         if (!cmd.listen) begin
            rx_active_in = 1'b0;
         end else if (!rx_active_ff) begin
            if (cmd.line) begin
               rx_active_in = 1'b1;
               rx_idx_in    = '0;
               rx_shift_in  = '0;
               rx_timer_in  = {1'b0, cfg.bit_ticks[TICK_W-1:1]};
            end
         end else if (rx_timer_ff <= 16'd1) begin
            rx_timer_in = '0;
            for (int j = 0; j < CHAR_W; j++) begin
               if (rx_idx_ff == BIT_W'(j + 1)) begin
                  rx_shift_in[j] = ~cmd.line;
               end
            end
            if (rx_idx_ff >= RX_STOP_BIT) begin
               push.valid   = 1'b1;
               rx_active_in = 1'b0;
               rx_idx_in    = '0;
            end else begin
               rx_idx_in   = rx_idx_ff + 4'd1;
               rx_timer_in = cfg.bit_ticks;
            end
         end else begin
            rx_timer_in = rx_timer_ff - 16'd1;
         end
      end else begin
         if (cmd.wake) begin
            tx_phase_in = TX_WAKE_HI;
            tx_timer_in = cfg.wake_high;
         end
         if (cmd.send) begin
            tx_phase_in = TX_FRAME;
            tx_frame_in = build_frame(cmd.tx_char);
            tx_idx_in   = '0;
            tx_timer_in = cfg.bit_ticks;
         end
         if (cmd.rx_abort) begin
            rx_active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tx_phase_ff  <= TX_IDLE;
         tx_frame_ff  <= '0;
         tx_idx_ff    <= '0;
         tx_timer_ff  <= '0;
         rx_active_ff <= 1'b0;
         rx_idx_ff    <= '0;
         rx_timer_ff  <= '0;
      end else begin
         tx_phase_ff  <= tx_phase_in;
         tx_frame_ff  <= tx_frame_in;
         tx_idx_ff    <= tx_idx_in;
         tx_timer_ff  <= tx_timer_in;
         rx_active_ff <= rx_active_in;
         rx_idx_ff    <= rx_idx_in;
         rx_timer_ff  <= rx_timer_in;
      end
      rx_shift_ff <= rx_shift_in;
   end

   assign stat.busy  = (tx_phase_ff != TX_IDLE);
   assign stat.level = (tx_phase_ff == TX_WAKE_HI) ||
                       ((tx_phase_ff == TX_FRAME) && tx_frame_ff[tx_idx_ff]);

endmodule

### design/sdi12_line_transceiver.sv
// ----------------------------------------------------------------------------
// sdi12_line_transceiver
// Inverted-logic single-wire serial line interface with receive ring.
// ----------------------------------------------------------------------------
// One request transaction is taken every clock cycle while req_ready is high;
// its response transaction is offered in the next cycle and reports the state
// after the request. The response is held in one output stage, and req_ready
// stays high while that stage is empty or being drained, so back-to-back
// traffic runs at one request per cycle. Read and peek fetch the character
// through the ring memory's registered read port. Only tick requests advance
// line timing (one tick per bit_ticks counts of a bit). The
// ring has 64 entries and holds at most 63 characters; its contents are not
// cleared at reset and no clearing pass runs, so requests are taken right
// after reset. Configuration writes are always accepted (csr_ready is tied
// high) and must only be issued while no transaction is outstanding.
// ----------------------------------------------------------------------------
module sdi12_line_transceiver
   import sdi12_pkg::*;
(
   input  logic              clock,
   input  logic              reset,

   // request channel
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [3:0]        req_type,
   input  logic              req_line_in,
   input  logic [CHAR_W-1:0] req_tx_char,

   // response channel
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_line_high,
   output logic              rsp_drive_enable,
   output logic [CHAR_W-1:0] rsp_rx_char,
   output logic              rsp_rx_valid,
   output logic [FILL_W-1:0] rsp_fill_count,
   output logic              rsp_overflow,
   output logic              rsp_busy_res,
   output logic [1:0]        rsp_line_mode,

   // configuration write channel
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [CSR_IW-1:0] csr_index,
   input  logic [TICK_W-1:0] csr_data
);

   // ---------------------------------------------------------------- state
   line_cfg_type       cfg_ff;
   logic [1:0]         mode_ff, mode_in;
   logic [RING_AW-1:0] rd_idx_ff, rd_idx_in;
   logic [RING_AW-1:0] wr_idx_ff, wr_idx_in;
   logic               ovf_ff, ovf_in;
   logic               rsp_valid_ff;
   logic               rx_valid_ff, rx_valid_in;

   logic               req_accept;
   logic               host_req;   // line control request (wake..disable)
   logic               ring_empty;
   logic [RING_AW-1:0] wr_idx_next;
   logic [RING_AW-1:0] rd_idx_next;
   logic [RING_AW-1:0] fill;

   line_cmd_type       line_cmd;
   line_stat_type      line_stat;
   line_push_type      line_push;

   logic               ram_wr_en;
   logic               ram_rd_en;
   logic [CHAR_W-1:0]  ram_rd_data;

   // ------------------------------------------------------------- handshake
   // Next request only when the response stage is free or drains this cycle.
   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;
   assign csr_ready  = 1'b1;

   assign host_req = (req_type == REQ_WAKE)   || (req_type == REQ_SEND) ||
                     (req_type == REQ_LISTEN) || (req_type == REQ_HOLD) ||
                     (req_type == REQ_DISABLE);

   // ------------------------------------------------------------- line engine
   always_comb begin
      line_cmd          = '0;
      line_cmd.line     = req_line_in;
      line_cmd.tx_char  = req_tx_char;
      line_cmd.listen   = (mode_ff == MODE_LISTEN);
      line_cmd.tick     = req_accept && (req_type == REQ_TICK);
      // line control is ignored while a wake or frame is running
      line_cmd.wake     = req_accept && !line_stat.busy && (req_type == REQ_WAKE);
      line_cmd.send     = req_accept && !line_stat.busy && (req_type == REQ_SEND);
      line_cmd.rx_abort = req_accept && !line_stat.busy && host_req;
   end

   sdi12_line_engine u_line (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg_ff),
      .cmd   (line_cmd),
      .stat  (line_stat),
      .push  (line_push)
   );

   // -------------------------------------------------------------- ring control
   assign wr_idx_next = (wr_idx_ff == RING_AW'(RING_DEPTH - 1)) ? '0 :
                        wr_idx_ff + RING_AW'(1);
   assign rd_idx_next = (rd_idx_ff == RING_AW'(RING_DEPTH - 1)) ? '0 :
                        rd_idx_ff + RING_AW'(1);
   assign ring_empty  = (rd_idx_ff == wr_idx_ff);

   // A completed character is written only when the ring has room; the push
   // and a host read never share a cycle, so no forwarding is needed.
   assign ram_wr_en = line_push.valid && (wr_idx_next != rd_idx_ff);
   assign ram_rd_en = req_accept && ((req_type == REQ_READ) || (req_type == REQ_PEEK));

   always_comb begin
      mode_in     = mode_ff;
      rd_idx_in   = rd_idx_ff;
      wr_idx_in   = wr_idx_ff;
      ovf_in      = ovf_ff;
      rx_valid_in = rx_valid_ff;

      if (line_push.valid) begin
         if (ram_wr_en) begin
            wr_idx_in = wr_idx_next;
         end else begin
            ovf_in = 1'b1;
         end
      end

      if (req_accept) begin
         rx_valid_in = 1'b0;
         unique case (req_type)
            REQ_WAKE, REQ_SEND: begin
               if (!line_stat.busy) mode_in = MODE_TX;
            end
            REQ_LISTEN: begin
               if (!line_stat.busy) mode_in = MODE_LISTEN;
            end
            REQ_HOLD: begin
               if (!line_stat.busy) mode_in = MODE_HOLD;
            end
            REQ_DISABLE: begin
               if (!line_stat.busy) mode_in = MODE_OFF;
            end
            REQ_READ: begin
               ovf_in      = 1'b0;
               rx_valid_in = !ring_empty;
               if (!ring_empty) rd_idx_in = rd_idx_next;
            end
            REQ_PEEK: begin
               rx_valid_in = !ring_empty;
            end
            REQ_FLUSH: begin
               rd_idx_in = '0;
               wr_idx_in = '0;
               ovf_in    = 1'b0;
            end
            default: begin
               // tick and unused codes: nothing here
            end
         endcase
      end
   end

   sdi12_ring_ram u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wr_idx_ff),
      .wr_data (line_push.data),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_idx_ff),
      .rd_data (ram_rd_data)
   );

   // ------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bit_ticks <= BIT_TICKS_RST;
         cfg_ff.wake_high <= WAKE_HIGH_RST;
         cfg_ff.wake_low  <= WAKE_LOW_RST;
         mode_ff          <= MODE_OFF;
         rd_idx_ff        <= '0;
         wr_idx_ff        <= '0;
         ovf_ff           <= 1'b0;
         rx_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_BIT_TICKS: cfg_ff.bit_ticks <= csr_data;
               CSR_WAKE_HIGH: cfg_ff.wake_high <= csr_data;
               CSR_WAKE_LOW:  cfg_ff.wake_low  <= csr_data;
               default: begin
                  // writes past the register list are dropped
               end
            endcase
         end
         mode_ff     <= mode_in;
         rd_idx_ff   <= rd_idx_in;
         wr_idx_ff   <= wr_idx_in;
         ovf_ff      <= ovf_in;
         rx_valid_ff <= rx_valid_in;
         if (req_accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // -------------------------------------------------------------- response
   // State changes only on an accepted request, so the pending response is
   // read straight from the state registers.
   assign fill = wr_idx_ff - rd_idx_ff + ((wr_idx_ff < rd_idx_ff) ?
                 RING_AW'(RING_DEPTH) : '0);

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_line_high    = line_stat.level;
   assign rsp_drive_enable = (mode_ff == MODE_HOLD) || (mode_ff == MODE_TX);
   assign rsp_rx_char      = rx_valid_ff ? ram_rd_data : '0;
   assign rsp_rx_valid     = rx_valid_ff;
   assign rsp_fill_count   = FILL_W'(fill);
   assign rsp_overflow     = ovf_ff;
   assign rsp_busy_res     = line_stat.busy;
   assign rsp_line_mode    = mode_ff;

   // ------------------------------------------------------------ assertions
`ifndef NO_ASSERTIONS
   // the line is never shown high while released
   a_level_needs_drive: assert property (@(posedge clock) disable iff (reset)
      !rsp_drive_enable |-> !rsp_line_high)
      else $error("line high while not driven");

   // a wake or frame only runs in transmitting mode
   a_busy_in_tx: assert property (@(posedge clock) disable iff (reset)
      rsp_busy_res |-> (rsp_line_mode == MODE_TX))
      else $error("busy outside transmitting mode");

   // overflow is raised only by a tick that completes a character
   a_ovf_from_tick: assert property (@(posedge clock) disable iff (reset)
      $rose(ovf_ff) |-> $past(line_push.valid))
      else $error("overflow set without a received character");

   // a found character never leaves the ring apparently empty on peek
   a_peek_keeps_fill: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_type == REQ_PEEK)) |=> (rsp_rx_valid == (rsp_fill_count != '0)))
      else $error("peek result disagrees with fill count");
`endif

endmodule
